### hdl/assert_macros.svh
// Concurrent assertion macros shared by the supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SFCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define SFCS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SFCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define SFCS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/sfcs_pkg.sv
// Types and constants of the six-face calibration supervisor.
package sfcs_pkg;

	typedef enum logic [1:0] {
		MODE_CAL   = 2'd0,
		MODE_ENTER = 2'd1,
		MODE_NORM  = 2'd2,
		MODE_PRE   = 2'd3
	} mode_t;

	// register indexes, byte address is 4 * index
	localparam logic [2:0] REG_FACE_TOL  = 3'd0;
	localparam logic [2:0] REG_STEADY    = 3'd1;
	localparam logic [2:0] REG_RECALIB   = 3'd2;
	localparam logic [2:0] REG_PUB_EVERY = 3'd3;
	localparam logic [2:0] REG_REL_LEVEL = 3'd4;

	localparam logic [12:0] FACE_TOL_RST  = 13'd410;
	localparam logic [15:0] STEADY_RST    = 16'd3;
	localparam logic [15:0] RECALIB_RST   = 16'd600;
	localparam logic [7:0]  PUB_EVERY_RST = 8'd12;
	localparam logic [1:0]  REL_LEVEL_RST = 2'd3;

	localparam logic [16:0] ONE_G     = 17'd4096;
	localparam logic [5:0]  ALL_FACES = 6'h3f;

	localparam logic [1:0] FILT_CAL  = 2'd0;
	localparam logic [1:0] FILT_NORM = 2'd3;

endpackage

### hdl/sfcs_if.sv
// Valid/ready channels for samples in and results out.
interface sfcs_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [1:0]         orientation_status;
	logic [31:0]        now_seconds;

	modport source (output valid, accel_x, accel_y, accel_z, orientation_status,
		now_seconds, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, orientation_status,
		now_seconds, output ready);
endinterface

interface sfcs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] trusted_status;
	logic [5:0] faces_seen;
	logic       publish;
	logic [1:0] status_echo;

	modport source (output valid, mode, trusted_status, faces_seen, publish,
		status_echo, input ready);
	modport sink (input valid, mode, trusted_status, faces_seen, publish,
		status_echo, output ready);
endinterface

### hdl/sfcs_face_detect.sv
// Face test for one axis: plus face at bit 0, minus face at bit 1.
module sfcs_face_detect
	import sfcs_pkg::*;
(
	input  logic signed [15:0] accel,
	input  logic [12:0]        tolerance,
	output logic [1:0]         faces
);

	logic signed [16:0] ext;
	logic [16:0]        mag;
	logic [16:0]        gap;
	logic               hit;

	always_comb begin
		ext  = {accel[15], accel};
		mag  = ext[16] ? (17'd0 - ext) : ext;
		gap  = (mag >= ONE_G) ? (mag - ONE_G) : (ONE_G - mag);
		hit  = (accel != 16'sd0) && (gap <= {4'd0, tolerance});
		if (!hit) begin
			faces = 2'b00;
		end else if (accel[15]) begin
			faces = 2'b10;
		end else begin
			faces = 2'b01;
		end
	end

endmodule

### hdl/six_face_calibration_supervisor_top.sv
// Six-face calibration supervisor: mode sequencer, publish divider and APB registers.
// The result of an accepted sample is registered in the output register at the accepting edge.
// One sample per cycle while the output register is empty or being read; it refills in the cycle it is read.
// The only loop is mode/face/timer/filter/count state updated at the accepting edge.
// arst_n low clears mode, faces, timer, filter, sample count and the output valid,
// and loads the register reset values.
`include "assert_macros.svh"

module six_face_calibration_supervisor_top
	import sfcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sfcs_in_if.sink     sample,
	sfcs_out_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [12:0] face_tol_q;
	logic [15:0] steady_q;
	logic [15:0] recalib_q;
	logic [7:0]  pub_every_q;
	logic [1:0]  rel_level_q;

	// supervisor state
	mode_t       mode_q, mode_d;
	logic [5:0]  face_mask_q, face_mask_d;
	logic [31:0] timer_q, timer_d;
	logic [1:0]  filt_q, filt_d;
	logic [7:0]  cnt_q, cnt_d, cnt_inc;

	// output register
	logic        res_valid_q;
	mode_t       res_mode_q;
	logic [1:0]  res_filt_q;
	logic [5:0]  res_faces_q;
	logic        res_pub_q;
	logic [1:0]  res_status_q;

	logic        accept;
	logic        cfg_wr;
	logic [2:0]  reg_idx;
	logic        reliable;
	logic [31:0] elapsed;
	logic [1:0]  fx, fy, fz;
	logic [5:0]  faces_new;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_tol_q  <= FACE_TOL_RST;
			steady_q    <= STEADY_RST;
			recalib_q   <= RECALIB_RST;
			pub_every_q <= PUB_EVERY_RST;
			rel_level_q <= REL_LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FACE_TOL:  face_tol_q  <= pwdata[12:0];
				REG_STEADY:    steady_q    <= pwdata[15:0];
				REG_RECALIB:   recalib_q   <= pwdata[15:0];
				REG_PUB_EVERY: pub_every_q <= pwdata[7:0];
				REG_REL_LEVEL: rel_level_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FACE_TOL:  prdata = {19'd0, face_tol_q};
			REG_STEADY:    prdata = {16'd0, steady_q};
			REG_RECALIB:   prdata = {16'd0, recalib_q};
			REG_PUB_EVERY: prdata = {24'd0, pub_every_q};
			REG_REL_LEVEL: prdata = {30'd0, rel_level_q};
			default:       prdata = 32'd0;
		endcase
	end

	sfcs_face_detect u_face_x (.accel(sample.accel_x), .tolerance(face_tol_q), .faces(fx));
	sfcs_face_detect u_face_y (.accel(sample.accel_y), .tolerance(face_tol_q), .faces(fy));
	sfcs_face_detect u_face_z (.accel(sample.accel_z), .tolerance(face_tol_q), .faces(fz));

	assign faces_new = face_mask_q | {fz, fy, fx};
	assign reliable  = (sample.orientation_status == rel_level_q);
	assign elapsed   = sample.now_seconds - timer_q;

	assign sample.ready = !res_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_CAL: begin
				if ((faces_new == ALL_FACES) && reliable) mode_d = MODE_ENTER;
			end
			MODE_ENTER: begin
				if (!reliable) begin
					mode_d = MODE_CAL;
				end else if (elapsed >= {16'd0, steady_q}) begin
					mode_d = MODE_NORM;
				end
			end
			MODE_NORM: begin
				if (!reliable) mode_d = MODE_PRE;
			end
			MODE_PRE: begin
				if (reliable) begin
					mode_d = MODE_NORM;
				end else if (elapsed >= {16'd0, recalib_q}) begin
					mode_d = MODE_CAL;
				end
			end
			default: mode_d = MODE_CAL;
		endcase
	end

	// per-mode side effects
	always_comb begin
		face_mask_d = face_mask_q;
		timer_d     = timer_q;
		filt_d      = filt_q;
		unique case (mode_q)
			MODE_CAL: begin
				filt_d      = FILT_CAL;
				face_mask_d = faces_new;
				if ((faces_new == ALL_FACES) && reliable) timer_d = sample.now_seconds;
			end
			MODE_NORM: begin
				filt_d = FILT_NORM;
				if (!reliable) timer_d = sample.now_seconds;
			end
			default: ;
		endcase
	end

	// publish divider; a period of zero wraps every sample
	always_comb begin
		cnt_inc = cnt_q + 8'd1;
		cnt_d   = (cnt_inc >= pub_every_q) ? 8'd0 : cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CAL;
			face_mask_q <= 6'd0;
			timer_q     <= 32'd0;
			filt_q      <= FILT_CAL;
			cnt_q       <= 8'd0;
		end else if (accept) begin
			mode_q      <= mode_d;
			face_mask_q <= face_mask_d;
			timer_q     <= timer_d;
			filt_q      <= filt_d;
			cnt_q       <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_mode_q   <= mode_d;
			res_filt_q   <= filt_d;
			res_faces_q  <= face_mask_d;
			res_pub_q    <= (cnt_q == 8'd0);
			res_status_q <= sample.orientation_status;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.mode           = res_mode_q;
	assign result.trusted_status = res_filt_q;
	assign result.faces_seen     = res_faces_q;
	assign result.publish        = res_pub_q;
	assign result.status_echo    = res_status_q;

	// faces are sticky, leaving calibration needs all of them, an accepted sample fills the output, state holds otherwise
	`SFCS_ASSERT_ALWAYS(a_faces_sticky, clk, arst_n, (face_mask_q & $past(face_mask_q)) == $past(face_mask_q))
	`SFCS_ASSERT_IMPLIES(a_all_faces, clk, arst_n, mode_q != MODE_CAL, face_mask_q == ALL_FACES)
	`SFCS_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept, res_valid_q)
	`SFCS_ASSERT_NEXT(a_state_holds, clk, arst_n, !accept, $stable(mode_q) && $stable(cnt_q))

endmodule
